// ===== rtl/core/ocl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered character list package
// Command codes, status codes and the request and result payload types.
// ----------------------------------------------------------------------------
package ocl_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_READ   = 3'd2,
		CMD_FIND   = 3'd3,
		CMD_LENGTH = 3'd4,
		CMD_DUMP   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] position;
		logic [7:0] char_in;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] char_out;
		logic [7:0] index_out;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/core/ocl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered character list channel
// Valid/ready channel interface carrying one payload of type T.
// ----------------------------------------------------------------------------
interface ocl_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ordered_char_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered character list engine
// Ordered list of up to CAPACITY characters with positional edit commands.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (cmd, position, char_in) and results leave on
// res (status, char_out, index_out, last), both valid/ready channels.
// A two-entry queue sits between the request decoder and the list executor,
// so new requests are taken while a command runs. The executor moves or
// compares one entry per cycle. Insert shifts the entries from the given
// position up by one, or appends without a shift; delete shifts the
// entries after the position down by one, or none at the tail. Find
// compares entries from the head until a match or the end of the list.
// A dump gives one result per entry, in list order. After a result is
// loaded the executor takes the next queued command, or the next entry
// of a dump. Command codes 6 and 7 are dropped. Reset empties the list.
// When the receiver stalls, the held result waits in the output register
// and the executor halts until it is taken; the queue then fills and
// req.ready drops.
// ----------------------------------------------------------------------------
module ordered_char_list_engine #(
	parameter int CAPACITY = 32
) (
	input wire clk,
	input wire arst_n,
	ocl_if.sink   req,
	ocl_if.source res
);
	ocl_pkg::req_t q_data;
	logic q_valid, q_pop;

	ocl_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	ocl_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data),
		.q_valid(q_valid), .q_pop(q_pop), .res(res)
	);
endmodule
`default_nettype wire

// ===== rtl/core/ocl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered character list front end
// Accepts requests, drops unused command codes and queues the rest.
// ----------------------------------------------------------------------------
module ocl_front (
	input  wire          clk,
	input  wire          arst_n,
	ocl_if.sink          req,
	output ocl_pkg::req_t q_data,
	output logic         q_valid,
	input  wire          q_pop
);
	ocl_pkg::req_t mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push, known;

	assign known = (req.data.cmd <= ocl_pkg::CMD_DUMP);
	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready && known;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= req.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !req.ready) else $error("ready while full");
endmodule
`default_nettype wire

// ===== rtl/core/ocl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered character list back end
// Executes queued commands on the entry store, moving or comparing one entry per cycle.
// ----------------------------------------------------------------------------
module ocl_back #(
	parameter int CAPACITY = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	input  ocl_pkg::req_t q_data,
	input  wire           q_valid,
	output logic          q_pop,
	ocl_if.source         res
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_WAIT  = 6'b000100,
		S_RUN   = 6'b001000,
		S_PUT   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	logic [7:0] store_q [CAPACITY];
	state_t     state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	ocl_pkg::req_t cur_q;
	logic [7:0] rd_q;
	logic       out_valid_q;
	ocl_pkg::res_t out_q;
	ocl_pkg::res_t pend_q;
	logic       out_free;
	logic       load_out;
	logic       we;
	logic [AW-1:0] wa;
	logic [7:0] wd;
	logic [AW-1:0] ra;
	logic [7:0] posc;
	logic [8:0] cnt9;
	logic [CW-1:0] pos_m1;
	logic [CW-1:0] last_idx;
	logic       valid_pos;

	assign out_free = !out_valid_q || res.ready;
	assign load_out = (state_q == S_OUT) && out_free;
	assign res.valid = out_valid_q;
	assign res.data = out_q;
	assign posc = cur_q.position;
	assign cnt9 = 9'(count_q);
	assign pos_m1 = CW'(posc - 8'd1);
	assign last_idx = count_q - CW'(1);

	function automatic ocl_pkg::res_t mk(input ocl_pkg::status_t s,
		input logic [7:0] c, input logic [7:0] i, input logic l);
		ocl_pkg::res_t r;
		r.status = s;
		r.char_out = c;
		r.index_out = i;
		r.last = l;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (we) store_q[wa] <= wd;
		rd_q <= store_q[ra];
	end

	// The read runs one entry ahead of the write, so a shift moves one entry
	// per cycle through the single write port.
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		ra = AW'(k_q);
		case (state_q)
			S_RUN: begin
				case (cur_q.cmd)
					ocl_pkg::CMD_INSERT: begin
						we = 1'b1;
						wa = AW'(k_q + CW'(1));
						wd = rd_q;
						ra = AW'(k_q - CW'(1));
					end
					ocl_pkg::CMD_DELETE: begin
						we = 1'b1;
						wa = AW'(k_q - CW'(1));
						wd = rd_q;
						ra = AW'(k_q + CW'(1));
					end
					ocl_pkg::CMD_FIND: ra = AW'(k_q + CW'(1));
					default: ;
				endcase
			end
			S_PUT: begin
				we = 1'b1;
				wa = AW'(pos_m1);
				wd = cur_q.char_in;
			end
			S_OUT: ra = AW'(k_q + CW'(1));
			default: ;
		endcase
	end

	always_comb begin
		if (cur_q.cmd == ocl_pkg::CMD_INSERT)
			valid_pos = (posc != 8'd0) && ({1'b0, posc} <= cnt9 + 9'd1);
		else
			valid_pos = (posc != 8'd0) && ({1'b0, posc} <= cnt9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !res.ready);
			if (load_out) out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q <= '0;
			cur_q <= '0;
			pend_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_data;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_OUT;
					case (cur_q.cmd)
						ocl_pkg::CMD_INSERT: begin
							if (!valid_pos)
								pend_q <= mk(ocl_pkg::ST_BADPOS, '0, '0, 1'b1);
							else if (count_q == CW'(CAPACITY))
								pend_q <= mk(ocl_pkg::ST_FULL, '0, '0, 1'b1);
							else if (pos_m1 == count_q)
								state_q <= S_PUT;
							else begin
								k_q <= last_idx;
								state_q <= S_WAIT;
							end
						end
						ocl_pkg::CMD_DELETE: begin
							if (!valid_pos)
								pend_q <= mk(ocl_pkg::ST_BADPOS, '0, '0, 1'b1);
							else if (CW'(posc) == count_q) begin
								count_q <= last_idx;
								pend_q <= mk(ocl_pkg::ST_OK, '0, '0, 1'b1);
							end else begin
								k_q <= CW'(posc);
								state_q <= S_WAIT;
							end
						end
						ocl_pkg::CMD_READ: begin
							if (!valid_pos)
								pend_q <= mk(ocl_pkg::ST_BADPOS, '0, '0, 1'b1);
							else begin
								k_q <= pos_m1;
								state_q <= S_WAIT;
							end
						end
						ocl_pkg::CMD_LENGTH: begin
							pend_q <= mk(ocl_pkg::ST_OK, '0, 8'(count_q), 1'b1);
						end
						default: begin
							if (count_q == '0)
								pend_q <= mk(ocl_pkg::ST_NOTFOUND, '0, '0, 1'b1);
							else begin
								k_q <= '0;
								state_q <= S_WAIT;
							end
						end
					endcase
				end
				S_WAIT: begin
					// The first read address is presented here.
					state_q <= S_RUN;
				end
				S_RUN: begin
					case (cur_q.cmd)
						ocl_pkg::CMD_INSERT: begin
							if (k_q == pos_m1) state_q <= S_PUT;
							else k_q <= k_q - CW'(1);
						end
						ocl_pkg::CMD_DELETE: begin
							if (k_q == last_idx) begin
								count_q <= last_idx;
								pend_q <= mk(ocl_pkg::ST_OK, '0, '0, 1'b1);
								state_q <= S_OUT;
							end else k_q <= k_q + CW'(1);
						end
						ocl_pkg::CMD_READ: begin
							if (rd_q == ocl_pkg::NEWLINE_CHAR)
								pend_q <= mk(ocl_pkg::ST_NOTFOUND, '0, '0, 1'b1);
							else pend_q <= mk(ocl_pkg::ST_OK, rd_q, '0, 1'b1);
							state_q <= S_OUT;
						end
						ocl_pkg::CMD_FIND: begin
							if (rd_q == cur_q.char_in) begin
								pend_q <= mk(ocl_pkg::ST_OK, '0, 8'(k_q + CW'(1)), 1'b1);
								state_q <= S_OUT;
							end else if (k_q == last_idx) begin
								pend_q <= mk(ocl_pkg::ST_NOTFOUND, '0, '0, 1'b1);
								state_q <= S_OUT;
							end else k_q <= k_q + CW'(1);
						end
						default: begin
							pend_q <= mk(ocl_pkg::ST_OK, rd_q, '0, k_q == last_idx);
							state_q <= S_OUT;
						end
					endcase
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					pend_q <= mk(ocl_pkg::ST_OK, '0, '0, 1'b1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						if (cur_q.cmd == ocl_pkg::CMD_DUMP && !pend_q.last) begin
							k_q <= k_q + CW'(1);
							state_q <= S_RUN;
						end else state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> $stable(res.data)) else $error("result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE) else $error("pop while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
endmodule
`default_nettype wire
